// ===== sv/psa_pkg.sv =====
// Shared types and codes of the pool segment allocator.
`timescale 1ns / 1ps
package psa_pkg;

	localparam int BYTES_W  = 25;
	localparam int START_W  = 25;
	localparam int COUNT_W  = 22;
	localparam int HANDLE_W = 8;
	localparam int OFFSET_W = 24;
	localparam int SLACK_W  = 16;

	localparam logic [SLACK_W-1:0] SLACK_RESET = 16'd50;
	localparam logic [BYTES_W-1:0] POOL_RESET  = 25'd16777216;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_OOM   = 2'd1;
	localparam logic [1:0] STAT_NOENT = 2'd2;

	localparam logic CFG_SLACK = 1'b0;
	localparam logic CFG_POOL  = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_A_WALK, S_A_CHK, S_A_SPLIT, S_A_APP,
		S_F_H, S_F_PT, S_F_PT2, S_F_NRD, S_F_N, S_F_N2, S_F_N3,
		S_F_H2RD, S_F_H2, S_F_P, S_F_P2, S_F_P3,
		S_LU_N, S_LU_P, S_AU_N, S_AU_P, S_P_RD, S_P_WR, S_DONE
	} state_t;

	typedef enum logic [2:0] {
		PT_LPREV, PT_LNEXT, PT_APREV, PT_ANEXT, PT_ADD
	} patch_op_t;

	typedef struct packed {
		logic                set_en;
		logic [HANDLE_W-1:0] set_idx;
		logic                clr_a_en;
		logic [HANDLE_W-1:0] clr_a_idx;
		logic                clr_b_en;
		logic [HANDLE_W-1:0] clr_b_idx;
	} slot_upd_t;

endpackage

// ===== sv/psa_table.sv =====
// Segment table memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module psa_table #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 86
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/psa_slots.sv =====
// Entry-in-use flags and a two-level registered search for the lowest unused entry.
`timescale 1ns / 1ps
module psa_slots
	import psa_pkg::*;
#(
	parameter int SPAN = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  slot_upd_t           upd,
	input  logic [HANDLE_W-1:0] probe_idx,
	output logic                probe_used,
	output logic                first_ok,
	output logic [HANDLE_W-1:0] first_idx
);

	logic [255:0] used_q;
	logic [15:0]  grp_any_s1;
	logic [3:0]   grp_idx_s1 [16];
	logic         first_ok_q;
	logic [7:0]   first_idx_q;
	logic [15:0]  grp_any;
	logic [3:0]   grp_idx [16];
	logic         top_any;
	logic [7:0]   top_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (upd.set_en) begin
				used_q[upd.set_idx] <= 1'b1;
			end
			if (upd.clr_a_en) begin
				used_q[upd.clr_a_idx] <= 1'b0;
			end
			if (upd.clr_b_en) begin
				used_q[upd.clr_b_idx] <= 1'b0;
			end
		end
	end

	// First level: lowest free entry inside each group of sixteen.
	always_comb begin
		for (int g = 0; g < 16; g++) begin
			grp_any[g] = 1'b0;
			grp_idx[g] = '0;
			for (int j = 15; j >= 0; j--) begin
				if (!used_q[g*16+j] && (g*16+j < SPAN)) begin
					grp_any[g] = 1'b1;
					grp_idx[g] = 4'(j);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_any_s1 <= grp_any;
		grp_idx_s1 <= grp_idx;
	end

	// Second level: lowest group that has a free entry.
	always_comb begin
		top_any = 1'b0;
		top_idx = '0;
		for (int g = 15; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				top_any = 1'b1;
				top_idx = {4'(g), grp_idx_s1[g]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_ok_q <= 1'b0;
		end else begin
			first_ok_q <= top_any;
		end
	end

	always_ff @(posedge clk) begin
		first_idx_q <= top_idx;
	end

	assign probe_used = used_q[probe_idx];
	assign first_ok   = first_ok_q;
	assign first_idx  = first_idx_q;

endmodule

// ===== sv/pool_segment_allocator_core.sv =====
// Top level of the pool segment allocator: control sequencer around the segment table.
// Usage:
// An item on the request channel (req_valid, req_stall) is either an allocate of count
// elements (kind 0) or a free of a segment handle (kind 1). Each item yields exactly one
// item on the response channel (rsp_valid, rsp_stall): status, seg_handle, byte_offset and
// the peak end offset. The user must write the two configuration registers (fit slack, pool
// size) through cfg_valid / cfg_ready / cfg_index / cfg_data only while the block is idle;
// the block itself does not enforce this. All segment records live in one synchronous table
// memory with registered read data, one access at a time; an update of an existing record
// is a read followed by a write of the same record, while a new record is written directly.
// An allocate walks the free list, reading and checking each entry examined, then takes,
// splits or appends and patches the links; the work of a free depends on how many neighbors merge.
// The free-list walk through the table port sets the rate; one item is in work at a time,
// and the next item is taken in the cycle after the previous response has been loaded.
// Reset clears the entry flags, list heads, offsets and counters at once; table contents
// need no clearing because entries are written before they are read.
// A finished response waits in an output register; while rsp_stall is high the response
// holds and the block can still take the next item, but will not finish it until the
// register frees up.
`timescale 1ns / 1ps
module pool_segment_allocator_core
	import psa_pkg::*;
#(
	parameter int MAX_SEGMENTS   = 256,
	parameter int ELEM_BYTES     = 8,
	parameter int POOL_ADDR_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                kind,
	input  logic [COUNT_W-1:0]  count,
	input  logic [HANDLE_W-1:0] handle,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [1:0]          status,
	output logic [HANDLE_W-1:0] seg_handle,
	output logic [OFFSET_W-1:0] byte_offset,
	output logic [BYTES_W-1:0]  peak_end,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [BYTES_W-1:0]  cfg_data
);

	// Links hold an entry number or the null value MAX_SEGMENTS.
	localparam int IW     = $clog2(MAX_SEGMENTS + 1);
	localparam int AW     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int SPAN   = (MAX_SEGMENTS < 256) ? MAX_SEGMENTS : 256;
	localparam int NEED_W = COUNT_W + $clog2(ELEM_BYTES) + 1;
	localparam int CW     = ((NEED_W > BYTES_W) ? NEED_W : BYTES_W) + 2;
	localparam logic [IW-1:0] NIL = IW'(MAX_SEGMENTS);
	localparam logic [BYTES_W:0] CAP_LIM = (POOL_ADDR_BITS >= BYTES_W) ?
		(BYTES_W+1)'(64'd1 << BYTES_W) : (BYTES_W+1)'(64'd1 << POOL_ADDR_BITS);

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [BYTES_W-1:0] bytes;
		logic               busy;
		logic [IW-1:0]      aprev;
		logic [IW-1:0]      anext;
		logic [IW-1:0]      lprev;
		logic [IW-1:0]      lnext;
	} rec_t;

	localparam int DW = $bits(rec_t);

	function automatic logic is_nil(input logic [IW-1:0] x);
		return (32'(x) >= MAX_SEGMENTS);
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] x);
		return AW'(x);
	endfunction

	state_t state_q, state_d;

	logic [SLACK_W-1:0] slack_q;
	logic [BYTES_W-1:0] pool_q;
	logic [IW-1:0]      ft_q, ft_d, st_q, st_d;
	logic [BYTES_W-1:0] end_q, end_d, hw_q, hw_d;
	logic [IW-1:0]      fc_q, fc_d, ec_q, ec_d;

	logic [NEED_W-1:0]  need_q, need_d;
	logic [IW-1:0]      t_q, t_d, steps_q, steps_d, h_q, h_d;
	rec_t               cur_q, cur_d, aux_q, aux_d;
	logic [IW-1:0]      lu_p_q, lu_p_d, lu_n_q, lu_n_d;
	state_t             lu_ret_q, lu_ret_d;
	logic [IW-1:0]      au_x_q, au_x_d, au_p_q, au_p_d, au_n_q, au_n_d;
	state_t             au_ret_q, au_ret_d;
	logic [IW-1:0]      pt_idx_q, pt_idx_d;
	patch_op_t          pt_op_q, pt_op_d;
	logic [BYTES_W-1:0] pt_val_q, pt_val_d;
	state_t             pt_ret_q, pt_ret_d;

	logic [1:0]          res_status_q, res_status_d;
	logic [HANDLE_W-1:0] res_handle_q, res_handle_d;
	logic [START_W-1:0]  res_off_q, res_off_d;

	logic                rsp_valid_q, rsp_load;
	logic [1:0]          status_q;
	logic [HANDLE_W-1:0] seg_handle_q;
	logic [OFFSET_W-1:0] byte_offset_q;
	logic [BYTES_W-1:0]  peak_end_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	rec_t          wr_rec, rd_rec;
	logic [DW-1:0] rd_data;

	slot_upd_t           upd;
	logic                probe_used, first_ok;
	logic [HANDLE_W-1:0] first_idx;
	logic [IW-1:0]       new_e;

	logic [NEED_W-1:0] need_w;
	logic [CW-1:0]     end_need;
	logic [BYTES_W:0]  limit;
	logic              handle_bad;

	psa_table #(.DEPTH(MAX_SEGMENTS), .AW(AW), .DW(DW)) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_rec),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	psa_slots #(.SPAN(SPAN)) u_slots (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.probe_idx  (handle),
		.probe_used (probe_used),
		.first_ok   (first_ok),
		.first_idx  (first_idx)
	);

	assign rd_rec     = rec_t'(rd_data);
	assign need_w     = NEED_W'(count) * NEED_W'(ELEM_BYTES);
	assign end_need   = CW'(end_q) + CW'(need_q);
	assign limit      = ({1'b0, pool_q} > CAP_LIM) ? CAP_LIM : {1'b0, pool_q};
	assign handle_bad = (32'(handle) >= MAX_SEGMENTS) || !probe_used;
	assign new_e      = IW'(first_idx);

	assign req_stall   = (state_q != S_IDLE);
	assign cfg_ready   = 1'b1;
	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign seg_handle  = seg_handle_q;
	assign byte_offset = byte_offset_q;
	assign peak_end    = peak_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slack_q     <= SLACK_RESET;
			pool_q      <= POOL_RESET;
			ft_q        <= NIL;
			st_q        <= NIL;
			end_q       <= '0;
			hw_q        <= '0;
			fc_q        <= '0;
			ec_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ft_q        <= ft_d;
			st_q        <= st_d;
			end_q       <= end_d;
			hw_q        <= hw_d;
			fc_q        <= fc_d;
			ec_q        <= ec_d;
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
			if (cfg_valid) begin
				if (cfg_index == CFG_SLACK) begin
					slack_q <= cfg_data[SLACK_W-1:0];
				end else begin
					pool_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		need_q       <= need_d;
		t_q          <= t_d;
		steps_q      <= steps_d;
		h_q          <= h_d;
		cur_q        <= cur_d;
		aux_q        <= aux_d;
		lu_p_q       <= lu_p_d;
		lu_n_q       <= lu_n_d;
		lu_ret_q     <= lu_ret_d;
		au_x_q       <= au_x_d;
		au_p_q       <= au_p_d;
		au_n_q       <= au_n_d;
		au_ret_q     <= au_ret_d;
		pt_idx_q     <= pt_idx_d;
		pt_op_q      <= pt_op_d;
		pt_val_q     <= pt_val_d;
		pt_ret_q     <= pt_ret_d;
		res_status_q <= res_status_d;
		res_handle_q <= res_handle_d;
		res_off_q    <= res_off_d;
		if (rsp_load) begin
			status_q      <= res_status_q;
			seg_handle_q  <= res_handle_q;
			byte_offset_q <= OFFSET_W'(res_off_q);
			peak_end_q    <= hw_q;
		end
	end

	always_comb begin
		state_d      = state_q;
		ft_d         = ft_q;
		st_d         = st_q;
		end_d        = end_q;
		hw_d         = hw_q;
		fc_d         = fc_q;
		ec_d         = ec_q;
		need_d       = need_q;
		t_d          = t_q;
		steps_d      = steps_q;
		h_d          = h_q;
		cur_d        = cur_q;
		aux_d        = aux_q;
		lu_p_d       = lu_p_q;
		lu_n_d       = lu_n_q;
		lu_ret_d     = lu_ret_q;
		au_x_d       = au_x_q;
		au_p_d       = au_p_q;
		au_n_d       = au_n_q;
		au_ret_d     = au_ret_q;
		pt_idx_d     = pt_idx_q;
		pt_op_d      = pt_op_q;
		pt_val_d     = pt_val_q;
		pt_ret_d     = pt_ret_q;
		res_status_d = res_status_q;
		res_handle_d = res_handle_q;
		res_off_d    = res_off_q;
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_rec       = cur_q;
		rd_addr      = '0;
		upd          = '0;
		rsp_load     = 1'b0;

		case (state_q)
			S_IDLE: begin
				res_status_d = STAT_OK;
				res_handle_d = '0;
				res_off_d    = '0;
				if (req_valid) begin
					if (!kind) begin
						need_d  = need_w;
						t_d     = ft_q;
						steps_d = '0;
						state_d = S_A_WALK;
					end else begin
						h_d = IW'(handle);
						if (handle_bad) begin
							res_status_d = STAT_NOENT;
							state_d      = S_DONE;
						end else begin
							rd_addr = addr_of(IW'(handle));
							state_d = S_F_H;
						end
					end
				end
			end

			// Walk the free list from its newest entry backwards.
			S_A_WALK: begin
				if (is_nil(t_q) || (32'(steps_q) == MAX_SEGMENTS)) begin
					state_d = S_A_APP;
				end else begin
					rd_addr = addr_of(t_q);
					state_d = S_A_CHK;
				end
			end

			S_A_CHK: begin
				cur_d = rd_rec;
				if (CW'(rd_rec.bytes) >= CW'(need_q)) begin
					if (CW'(rd_rec.bytes) <= CW'(need_q) + CW'(slack_q)) begin
						wr_en        = 1'b1;
						wr_addr      = addr_of(t_q);
						wr_rec       = rd_rec;
						wr_rec.busy  = 1'b1;
						res_handle_d = HANDLE_W'(t_q);
						res_off_d    = rd_rec.start;
						lu_p_d       = rd_rec.lprev;
						lu_n_d       = rd_rec.lnext;
						lu_ret_d     = S_DONE;
						state_d      = S_LU_N;
					end else if (!first_ok) begin
						res_status_d = STAT_NOENT;
						state_d      = S_DONE;
					end else begin
						wr_en        = 1'b1;
						wr_addr      = addr_of(new_e);
						wr_rec.start = rd_rec.start;
						wr_rec.bytes = BYTES_W'(need_q);
						wr_rec.busy  = 1'b1;
						wr_rec.aprev = rd_rec.aprev;
						wr_rec.anext = t_q;
						wr_rec.lprev = NIL;
						wr_rec.lnext = NIL;
						upd.set_en   = 1'b1;
						upd.set_idx  = first_idx;
						ec_d         = ec_q + 1'b1;
						h_d          = new_e;
						res_handle_d = first_idx;
						res_off_d    = rd_rec.start;
						state_d      = S_A_SPLIT;
					end
				end else begin
					t_d     = rd_rec.lprev;
					steps_d = steps_q + 1'b1;
					state_d = S_A_WALK;
				end
			end

			// The free segment keeps the high part of a split.
			S_A_SPLIT: begin
				wr_en        = 1'b1;
				wr_addr      = addr_of(t_q);
				wr_rec       = cur_q;
				wr_rec.aprev = h_q;
				wr_rec.start = START_W'(CW'(cur_q.start) + CW'(need_q));
				wr_rec.bytes = cur_q.bytes - BYTES_W'(need_q);
				if (!is_nil(cur_q.aprev)) begin
					pt_idx_d = cur_q.aprev;
					pt_op_d  = PT_ANEXT;
					pt_val_d = BYTES_W'(h_q);
					pt_ret_d = S_DONE;
					state_d  = S_P_RD;
				end else begin
					state_d = S_DONE;
				end
			end

			S_A_APP: begin
				if (!first_ok) begin
					res_status_d = STAT_NOENT;
					state_d      = S_DONE;
				end else if (end_need >= CW'(limit)) begin
					res_status_d = STAT_OOM;
					state_d      = S_DONE;
				end else begin
					wr_en        = 1'b1;
					wr_addr      = addr_of(new_e);
					wr_rec.start = end_q;
					wr_rec.bytes = BYTES_W'(need_q);
					wr_rec.busy  = 1'b1;
					wr_rec.aprev = st_q;
					wr_rec.anext = NIL;
					wr_rec.lprev = NIL;
					wr_rec.lnext = NIL;
					upd.set_en   = 1'b1;
					upd.set_idx  = first_idx;
					ec_d         = ec_q + 1'b1;
					res_handle_d = first_idx;
					res_off_d    = end_q;
					st_d         = new_e;
					end_d        = BYTES_W'(end_need);
					if (BYTES_W'(end_need) > hw_q) begin
						hw_d = BYTES_W'(end_need);
					end
					if (!is_nil(st_q)) begin
						pt_idx_d = st_q;
						pt_op_d  = PT_ANEXT;
						pt_val_d = BYTES_W'(new_e);
						pt_ret_d = S_DONE;
						state_d  = S_P_RD;
					end else begin
						state_d = S_DONE;
					end
				end
			end

			// Single-field read-modify-write of one record.
			S_P_RD: begin
				rd_addr = addr_of(pt_idx_q);
				state_d = S_P_WR;
			end

			S_P_WR: begin
				wr_en   = 1'b1;
				wr_addr = addr_of(pt_idx_q);
				wr_rec  = rd_rec;
				case (pt_op_q)
					PT_LPREV: wr_rec.lprev = pt_val_q[IW-1:0];
					PT_LNEXT: wr_rec.lnext = pt_val_q[IW-1:0];
					PT_APREV: wr_rec.aprev = pt_val_q[IW-1:0];
					PT_ANEXT: wr_rec.anext = pt_val_q[IW-1:0];
					PT_ADD:   wr_rec.bytes = rd_rec.bytes + pt_val_q;
					default:  wr_rec = rd_rec;
				endcase
				state_d = pt_ret_q;
			end

			// Remove an entry from the free list.
			S_LU_N: begin
				fc_d = fc_q - 1'b1;
				if (is_nil(lu_n_q)) begin
					ft_d    = lu_p_q;
					state_d = S_LU_P;
				end else begin
					pt_idx_d = lu_n_q;
					pt_op_d  = PT_LPREV;
					pt_val_d = BYTES_W'(lu_p_q);
					pt_ret_d = S_LU_P;
					state_d  = S_P_RD;
				end
			end

			S_LU_P: begin
				if (!is_nil(lu_p_q)) begin
					pt_idx_d = lu_p_q;
					pt_op_d  = PT_LNEXT;
					pt_val_d = BYTES_W'(lu_n_q);
					pt_ret_d = lu_ret_q;
					state_d  = S_P_RD;
				end else begin
					state_d = lu_ret_q;
				end
			end

			// Remove an entry from the address chain and release it.
			S_AU_N: begin
				upd.clr_a_en  = 1'b1;
				upd.clr_a_idx = HANDLE_W'(au_x_q);
				ec_d          = ec_q - 1'b1;
				if (!is_nil(au_n_q)) begin
					pt_idx_d = au_n_q;
					pt_op_d  = PT_APREV;
					pt_val_d = BYTES_W'(au_p_q);
					pt_ret_d = S_AU_P;
					state_d  = S_P_RD;
				end else begin
					state_d = S_AU_P;
				end
			end

			S_AU_P: begin
				if (!is_nil(au_p_q)) begin
					pt_idx_d = au_p_q;
					pt_op_d  = PT_ANEXT;
					pt_val_d = BYTES_W'(au_n_q);
					pt_ret_d = au_ret_q;
					state_d  = S_P_RD;
				end else begin
					state_d = au_ret_q;
				end
			end

			S_F_H: begin
				cur_d = rd_rec;
				if (!rd_rec.busy) begin
					res_status_d = STAT_NOENT;
					state_d      = S_DONE;
				end else if (is_nil(rd_rec.anext)) begin
					// Last segment: the end offset shrinks.
					if (!is_nil(rd_rec.aprev)) begin
						rd_addr = addr_of(rd_rec.aprev);
						state_d = S_F_PT;
					end else begin
						st_d     = rd_rec.aprev;
						end_d    = end_q - rd_rec.bytes;
						au_x_d   = h_q;
						au_p_d   = rd_rec.aprev;
						au_n_d   = rd_rec.anext;
						au_ret_d = S_DONE;
						state_d  = S_AU_N;
					end
				end else begin
					wr_en        = 1'b1;
					wr_addr      = addr_of(h_q);
					wr_rec       = rd_rec;
					wr_rec.busy  = 1'b0;
					wr_rec.lprev = ft_q;
					wr_rec.lnext = NIL;
					fc_d         = fc_q + 1'b1;
					ft_d         = h_q;
					if (!is_nil(ft_q)) begin
						pt_idx_d = ft_q;
						pt_op_d  = PT_LNEXT;
						pt_val_d = BYTES_W'(h_q);
						pt_ret_d = S_F_NRD;
						state_d  = S_P_RD;
					end else begin
						state_d = S_F_NRD;
					end
				end
			end

			S_F_PT: begin
				aux_d = rd_rec;
				if (!rd_rec.busy) begin
					st_d     = rd_rec.aprev;
					end_d    = end_q - cur_q.bytes - rd_rec.bytes;
					lu_p_d   = rd_rec.lprev;
					lu_n_d   = rd_rec.lnext;
					lu_ret_d = S_F_PT2;
					state_d  = S_LU_N;
				end else begin
					st_d     = cur_q.aprev;
					end_d    = end_q - cur_q.bytes;
					au_x_d   = h_q;
					au_p_d   = cur_q.aprev;
					au_n_d   = cur_q.anext;
					au_ret_d = S_DONE;
					state_d  = S_AU_N;
				end
			end

			// Both the last segment and its free predecessor go away.
			S_F_PT2: begin
				upd.clr_a_en  = 1'b1;
				upd.clr_a_idx = HANDLE_W'(h_q);
				upd.clr_b_en  = 1'b1;
				upd.clr_b_idx = HANDLE_W'(cur_q.aprev);
				ec_d          = ec_q - 2'd2;
				if (!is_nil(aux_q.aprev)) begin
					pt_idx_d = aux_q.aprev;
					pt_op_d  = PT_ANEXT;
					pt_val_d = BYTES_W'(NIL);
					pt_ret_d = S_DONE;
					state_d  = S_P_RD;
				end else begin
					state_d = S_DONE;
				end
			end

			S_F_NRD: begin
				rd_addr = addr_of(cur_q.anext);
				state_d = S_F_N;
			end

			S_F_N: begin
				aux_d = rd_rec;
				if (!rd_rec.busy) begin
					pt_idx_d = h_q;
					pt_op_d  = PT_ADD;
					pt_val_d = rd_rec.bytes;
					pt_ret_d = S_F_N2;
					state_d  = S_P_RD;
				end else begin
					state_d = S_F_H2RD;
				end
			end

			S_F_N2: begin
				lu_p_d   = aux_q.lprev;
				lu_n_d   = aux_q.lnext;
				lu_ret_d = S_F_N3;
				state_d  = S_LU_N;
			end

			S_F_N3: begin
				au_x_d   = cur_q.anext;
				au_p_d   = aux_q.aprev;
				au_n_d   = aux_q.anext;
				au_ret_d = S_F_H2RD;
				state_d  = S_AU_N;
			end

			S_F_H2RD: begin
				rd_addr = addr_of(h_q);
				state_d = S_F_H2;
			end

			S_F_H2: begin
				cur_d = rd_rec;
				if (is_nil(rd_rec.aprev)) begin
					state_d = S_DONE;
				end else begin
					rd_addr = addr_of(rd_rec.aprev);
					state_d = S_F_P;
				end
			end

			S_F_P: begin
				if (!rd_rec.busy) begin
					pt_idx_d = cur_q.aprev;
					pt_op_d  = PT_ADD;
					pt_val_d = cur_q.bytes;
					pt_ret_d = S_F_P2;
					state_d  = S_P_RD;
				end else begin
					state_d = S_DONE;
				end
			end

			S_F_P2: begin
				lu_p_d   = cur_q.lprev;
				lu_n_d   = cur_q.lnext;
				lu_ret_d = S_F_P3;
				state_d  = S_LU_N;
			end

			S_F_P3: begin
				au_x_d   = h_q;
				au_p_d   = cur_q.aprev;
				au_n_d   = cur_q.anext;
				au_ret_d = S_DONE;
				state_d  = S_AU_N;
			end

			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	a_free_le_entries: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= ec_q)
		else $error("free list longer than the number of entries in use");

	a_end_le_peak: assert property (@(posedge clk) disable iff (!arst_n)
		end_q <= hw_q)
		else $error("end offset above its high-water mark");

	a_entries_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ec_q) <= SPAN)
		else $error("entry count above the handle span");

	a_load_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> (state_q == S_IDLE) && rsp_valid_q)
		else $error("response loaded outside the finishing step");

endmodule
